// ===== rtl/tdpt_pkg.sv =====
// Shared types and constants for the trial-division prime tester.
`default_nettype none

package tdpt_pkg;

    localparam int NUM_W = 32;
    localparam int CNT_W = $clog2(NUM_W);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(NUM_W - 1);
    localparam logic [NUM_W-1:0] FIRST_DIVISOR = NUM_W'(2);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_START,
        ST_WAIT,
        ST_DONE
    } seq_state_t;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] dividend;
        logic [NUM_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [NUM_W-1:0] quot;
        logic [NUM_W-1:0] rem;
    } div_rsp_t;

    typedef struct packed {
        logic             load;
        logic [NUM_W-1:0] number;
        logic             prime;
    } res_t;

endpackage

`default_nettype wire

// ===== rtl/trial_division_prime_test_top.sv =====
// Top level of the trial-division prime tester with its output register.
`default_nettype none

// Tests one 32-bit unsigned candidate at a time and returns it with a prime
// flag (0 and 1 report not prime). Divisors 2, 3, 4, ... are tried until one
// divides the candidate or the divisor exceeds the quotient (the square root
// is passed). Each trial runs through one shared radix-2 divider. The number
// of divisors tried is 1 for even numbers and up to about sqrt(candidate) for
// primes; 0 and 1 need no division at all. in_stall is high while a test runs
// and while its finished result waits for the output register. A finished
// result sits in the output register, and the next candidate is accepted while
// it waits to be taken.
module trial_division_prime_test_top
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_stall,
    input  wire logic [tdpt_pkg::NUM_W-1:0] candidate,
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output logic [tdpt_pkg::NUM_W-1:0]      tested_number,
    output logic                            is_prime
);

    tdpt_pkg::div_req_t             div_req;
    tdpt_pkg::div_rsp_t             div_rsp;
    tdpt_pkg::res_t                 res;
    logic                           busy;
    logic                           out_free;
    logic                           out_valid_reg, out_valid_next;
    logic [tdpt_pkg::NUM_W-1:0]     number_reg, number_next;
    logic                           prime_reg, prime_next;

    tdpt_seq u_seq
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .candidate (candidate),
        .busy      (busy),
        .out_free  (out_free),
        .div_req   (div_req),
        .div_rsp   (div_rsp),
        .res       (res)
    );

    tdpt_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign in_stall = busy;
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        number_next    = number_reg;
        prime_next     = prime_reg;
        if (res.load)
        begin
            out_valid_next = 1'b1;
            number_next    = res.number;
            prime_next     = res.prime;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        number_reg <= number_next;
        prime_reg  <= prime_next;
    end

    assign out_valid     = out_valid_reg;
    assign tested_number = number_reg;
    assign is_prime      = prime_reg;

endmodule

`default_nettype wire

// ===== rtl/tdpt_div.sv =====
// Restoring radix-2 divider: one quotient bit per cycle, quotient and remainder out.
`default_nettype none

module tdpt_div
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire tdpt_pkg::div_req_t req,
    output tdpt_pkg::div_rsp_t     rsp
);

    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [tdpt_pkg::CNT_W-1:0]    cnt_reg, cnt_next;
    logic [tdpt_pkg::NUM_W-1:0]    quo_reg, quo_next;
    logic [tdpt_pkg::NUM_W-1:0]    rem_reg, rem_next;
    logic [tdpt_pkg::NUM_W-1:0]    den_reg, den_next;
    logic [tdpt_pkg::NUM_W:0]      shifted;
    logic [tdpt_pkg::NUM_W:0]      trial;

    always_comb
    begin
        shifted   = {rem_reg, quo_reg[tdpt_pkg::NUM_W-1]};
        trial     = shifted - {1'b0, den_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = req.dividend;
            rem_next  = '0;
            den_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            // keep the trial difference unless it borrowed
            if (trial[tdpt_pkg::NUM_W])
            begin
                rem_next = shifted[tdpt_pkg::NUM_W-1:0];
                quo_next = {quo_reg[tdpt_pkg::NUM_W-2:0], 1'b0};
            end
            else
            begin
                rem_next = trial[tdpt_pkg::NUM_W-1:0];
                quo_next = {quo_reg[tdpt_pkg::NUM_W-2:0], 1'b1};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == tdpt_pkg::LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quo_reg;
    assign rsp.rem  = rem_reg;

endmodule

`default_nettype wire

// ===== rtl/tdpt_seq.sv =====
// Sequencer: steps the trial divisor and decides prime or composite.
`default_nettype none

module tdpt_seq
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    input  wire logic [tdpt_pkg::NUM_W-1:0] candidate,
    output logic                            busy,
    input  wire logic                       out_free,
    output tdpt_pkg::div_req_t              div_req,
    input  wire tdpt_pkg::div_rsp_t         div_rsp,
    output tdpt_pkg::res_t                  res
);

    tdpt_pkg::seq_state_t          state_reg, state_next;
    logic [tdpt_pkg::NUM_W-1:0]    num_reg, num_next;
    logic [tdpt_pkg::NUM_W-1:0]    div_reg, div_next;
    logic                          prime_reg, prime_next;

    always_comb
    begin
        state_next       = state_reg;
        num_next         = num_reg;
        div_next         = div_reg;
        prime_next       = prime_reg;
        div_req.start    = 1'b0;
        div_req.dividend = num_reg;
        div_req.divisor  = div_reg;
        res.load         = 1'b0;
        res.number       = num_reg;
        res.prime        = prime_reg;
        busy             = (state_reg != tdpt_pkg::ST_IDLE);
        case (state_reg)
            tdpt_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    num_next = candidate;
                    div_next = tdpt_pkg::FIRST_DIVISOR;
                    // zero and one are not prime
                    if (candidate < tdpt_pkg::FIRST_DIVISOR)
                    begin
                        prime_next = 1'b0;
                        state_next = tdpt_pkg::ST_DONE;
                    end
                    else
                    begin
                        state_next = tdpt_pkg::ST_START;
                    end
                end
            end
            tdpt_pkg::ST_START:
            begin
                div_req.start = 1'b1;
                state_next    = tdpt_pkg::ST_WAIT;
            end
            tdpt_pkg::ST_WAIT:
            begin
                if (div_rsp.done)
                begin
                    // divisor past the square root: no factor left
                    if (div_reg > div_rsp.quot)
                    begin
                        prime_next = 1'b1;
                        state_next = tdpt_pkg::ST_DONE;
                    end
                    else if (div_rsp.rem == '0)
                    begin
                        prime_next = 1'b0;
                        state_next = tdpt_pkg::ST_DONE;
                    end
                    else
                    begin
                        div_next   = div_reg + 1'b1;
                        state_next = tdpt_pkg::ST_START;
                    end
                end
            end
            tdpt_pkg::ST_DONE:
            begin
                // hold the answer until the output register frees up
                if (out_free)
                begin
                    res.load   = 1'b1;
                    state_next = tdpt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tdpt_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tdpt_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg   <= num_next;
        div_reg   <= div_next;
        prime_reg <= prime_next;
    end

endmodule

`default_nettype wire

// ===== tb/sv/trial_division_prime_test_top_tb.sv =====
// Self-checking testbench for the trial-division prime tester top level.
`timescale 1ns / 1ps

module trial_division_prime_test_top_tb;

    localparam int NUM_W = tdpt_pkg::NUM_W;

    typedef struct {
        bit [NUM_W-1:0] number;
        bit             prime;
    } verdict_t;

    class prime_scoreboard;
        verdict_t verdict_q[$];
        int       fail_count;
        int       result_count;
        int       prime_count;

        // Try divisors while d*d <= n; the first exact one makes n composite.
        function bit predict_prime(bit [NUM_W-1:0] n);
            bit [NUM_W-1:0] d;
            if (n < 2)
                return 0;
            d = 2;
            while (d <= n / d)
            begin
                if (n % d == 0)
                    return 0;
                d++;
            end
            return 1;
        endfunction

        function void note_candidate(bit [NUM_W-1:0] n);
            verdict_t v;
            v.number = n;
            v.prime  = predict_prime(n);
            verdict_q.push_back(v);
        endfunction

        function void check_result(logic [NUM_W-1:0] number, logic prime);
            verdict_t v;
            result_count++;
            if (verdict_q.size() == 0)
            begin
                $display("%0t: result with nothing pending: tested_number=%0d is_prime=%b",
                         $time, number, prime);
                fail_count++;
                return;
            end
            v = verdict_q.pop_front();
            if (v.prime)
                prime_count++;
            if (number !== v.number)
            begin
                $display("%0t: tested_number expected %0d actual %0d",
                         $time, v.number, number);
                fail_count++;
            end
            if (prime !== v.prime)
            begin
                $display("%0t: is_prime for %0d expected %b actual %b",
                         $time, v.number, v.prime, prime);
                fail_count++;
            end
        endfunction

        function int waiting();
            return verdict_q.size();
        endfunction
    endclass

    logic             clk;
    logic             rst_n;
    logic             in_valid;
    logic             in_stall;
    logic [NUM_W-1:0] candidate;
    logic             out_valid;
    logic             out_stall;
    logic [NUM_W-1:0] tested_number;
    logic             is_prime;

    prime_scoreboard board;
    int              sent_count;
    bit              long_hold_done;
    bit              drain_pause_done;

    trial_division_prime_test_top DUT
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .candidate     (candidate),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .tested_number (tested_number),
        .is_prime      (is_prime)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #50_000_000;
        $display("trial_division_prime_test_top_tb NOT OK");
        $finish;
    end

    // Offer one candidate after the given gap and hold it until accepted.
    task automatic send_candidate(input bit [NUM_W-1:0] value, input int gap);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        candidate <= value;
        do
            @(posedge clk);
        while (in_stall);
        board.note_candidate(value);
        sent_count++;
    endtask

    function automatic int draw_gap(int index);
        // Keep some stretches free of gaps.
        if ((index % 100) >= 50 && (index % 100) < 70)
            return 0;
        return $urandom_range(7, 0);
    endfunction

    // Mostly small values and large composites with a small factor, so primes
    // stay cheap; a share of mid-range values brings slower primes.
    function automatic bit [NUM_W-1:0] random_candidate();
        int             pick;
        bit [NUM_W-1:0] factor;
        bit [NUM_W-1:0] multiple;
        pick = $urandom_range(99, 0);
        if (pick < 45)
            return $urandom_range(4095, 0);
        if (pick < 85)
        begin
            factor   = $urandom_range(31, 2);
            multiple = $urandom_range(32'hFFFF_FFFF / factor, 1);
            return factor * multiple;
        end
        return $urandom_range(262143, 0);
    endfunction

    // Receiver: check each beat, then stall for a randomly drawn hold; one hold is long and some stretches have none.
    initial
    begin
        int hold_left;
        hold_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
            begin
                board.check_result(tested_number, is_prime);
                if (board.result_count == 40 && !long_hold_done)
                begin
                    hold_left      = 3000;
                    long_hold_done = 1'b1;
                end
                else if ((board.result_count % 90) >= 30 && (board.result_count % 90) < 50)
                    hold_left = 0;
                else
                    hold_left = $urandom_range(7, 0);
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
                out_stall <= 1'b0;
        end
    end

    initial
    begin
        bit [NUM_W-1:0] directed_q[$];
        int             drain_cycles;
        board            = new();
        sent_count       = 0;
        long_hold_done   = 1'b0;
        drain_pause_done = 1'b0;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        candidate = '0;
        out_stall = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Zero and one, the two smallest primes, squares of primes where the
        // divisor lands exactly on the root, slow primes and all-ones patterns.
        directed_q = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd9, 32'd25,
                       32'd49, 32'd121, 32'd1018081, 32'd65537, 32'd999983,
                       32'd1000003, 32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFE,
                       32'h5555_5555, 32'hAAAA_AAAA, 32'd257, 32'd257, 32'd255};
        foreach (directed_q[i])
            send_candidate(directed_q[i], draw_gap(i));

        for (int i = 0; i < 400; i++)
        begin
            // Pause the source until every pending result is back.
            if (i == 200)
            begin
                in_valid <= 1'b0;
                while (board.waiting() != 0)
                    @(posedge clk);
                drain_pause_done = 1'b1;
            end
            send_candidate(random_candidate(), draw_gap(i));
        end
        in_valid <= 1'b0;

        while (board.waiting() != 0)
            @(posedge clk);
        drain_cycles = 100;
        repeat (drain_cycles) @(posedge clk);

        $display("Sent %0d candidates, checked %0d results, %0d of them prime.",
                 sent_count, board.result_count, board.prime_count);
        $display("Long output hold: %0b, drained source pause: %0b.",
                 long_hold_done, drain_pause_done);
        if (board.fail_count == 0)
            $display("trial_division_prime_test_top_tb OK");
        else
            $display("trial_division_prime_test_top_tb NOT OK");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/tdpt_pkg.sv
rtl/tdpt_div.sv
rtl/tdpt_seq.sv
rtl/trial_division_prime_test_top.sv
tb/sv/trial_division_prime_test_top_tb.sv
